// ===== hdl/crc_pkg.sv =====
// Shared types and constants for the centripetal Catmull-Rom segment evaluator.
package crc_pkg;

	localparam int COORD_W      = 24;
	localparam int SEG_W        = 6;
	localparam int MAX_SEGMENTS = 63;
	localparam int SEG_RESET    = 12;
	localparam int KNOT_W       = 17;
	localparam int T_W          = KNOT_W + 2;
	localparam int KNOT_EXTRA   = 8;
	localparam int SQ_W         = 52;
	localparam int SQ_STEPS     = SQ_W / 2;
	localparam int KNOT_LAT     = 3 + 2 * SQ_STEPS;
	localparam int VAL_W        = 64;
	localparam int DEN_W        = T_W + 1;
	localparam int LERP_LAT     = VAL_W + 6;
	localparam int TDIV_W       = KNOT_W + SEG_W;

	typedef struct packed {
		logic signed [COORD_W-1:0] p0_x;
		logic signed [COORD_W-1:0] p0_y;
		logic signed [COORD_W-1:0] p1_x;
		logic signed [COORD_W-1:0] p1_y;
		logic signed [COORD_W-1:0] p2_x;
		logic signed [COORD_W-1:0] p2_y;
		logic signed [COORD_W-1:0] p3_x;
		logic signed [COORD_W-1:0] p3_y;
	} pts_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic                      last;
		logic                      degenerate;
	} crv_t;

	typedef struct packed {
		logic [T_W-1:0]            t1;
		logic [T_W-1:0]            t2;
		logic [T_W-1:0]            t3;
		logic [T_W-1:0]            t;
		logic signed [COORD_W-1:0] p1_x;
		logic signed [COORD_W-1:0] p1_y;
		logic                      last;
		logic                      degen;
		logic                      start;
	} side_t;

endpackage

// ===== hdl/crc_knot.sv =====
// Pipelined knot interval: fourth root of squared distance between two points.
module crc_knot (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [crc_pkg::COORD_W-1:0] ax,
	input  logic signed [crc_pkg::COORD_W-1:0] ay,
	input  logic signed [crc_pkg::COORD_W-1:0] bx,
	input  logic signed [crc_pkg::COORD_W-1:0] by,
	output logic [crc_pkg::KNOT_W-1:0]         k
);
	import crc_pkg::*;

	function automatic logic [2*SQ_W-1:0] sq_step(input logic [SQ_W-1:0] v,
		input logic [SQ_W-1:0] r, input int j);
		logic [SQ_W-1:0] b;
		logic [SQ_W-1:0] vn;
		logic [SQ_W-1:0] rn;
		b = SQ_W'(1) << (SQ_W - 2 - 2 * j);
		if (v >= r + b) begin
			vn = v - (r + b);
			rn = (r >> 1) + b;
		end else begin
			vn = v;
			rn = r >> 1;
		end
		return {vn, rn};
	endfunction

	logic signed [COORD_W:0]     dx_s1, dy_s1;
	logic signed [2*COORD_W+1:0] mx, my;
	logic [2*COORD_W+1:0]        sx_s2, sy_s2;
	logic [SQ_W-1:0]             a_s3;
	logic [SQ_W-1:0]             sq1_v_s [SQ_STEPS];
	logic [SQ_W-1:0]             sq1_r_s [SQ_STEPS];
	logic [SQ_W-1:0]             sq2_v_s [SQ_STEPS];
	logic [SQ_W-1:0]             sq2_r_s [SQ_STEPS];

	assign mx = dx_s1 * dx_s1;
	assign my = dy_s1 * dy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= {bx[COORD_W-1], bx} - {ax[COORD_W-1], ax};
			dy_s1 <= {by[COORD_W-1], by} - {ay[COORD_W-1], ay};
			sx_s2 <= mx;
			sy_s2 <= my;
			a_s3  <= SQ_W'(sx_s2) + SQ_W'(sy_s2);
		end
	end

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
		logic [SQ_W-1:0] v1_in, r1_in, v2_in, r2_in;
		if (j == 0) begin : g_first
			assign v1_in = a_s3;
			assign r1_in = '0;
			// second root works on s scaled up so the knot keeps resolution
			assign v2_in = sq1_r_s[SQ_STEPS-1] << KNOT_EXTRA;
			assign r2_in = '0;
		end else begin : g_next
			assign v1_in = sq1_v_s[j-1];
			assign r1_in = sq1_r_s[j-1];
			assign v2_in = sq2_v_s[j-1];
			assign r2_in = sq2_r_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				{sq1_v_s[j], sq1_r_s[j]} <= sq_step(v1_in, r1_in, j);
				{sq2_v_s[j], sq2_r_s[j]} <= sq_step(v2_in, r2_in, j);
			end
		end
	end

	assign k = sq2_r_s[SQ_STEPS-1][KNOT_W-1:0];

endmodule

// ===== hdl/crc_lerp.sv =====
// Pipelined pyramid level: (a*(tb-t) + b*(t-ta)) / (tb-ta), rounded half up.
module crc_lerp (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [crc_pkg::VAL_W-1:0]  a,
	input  logic signed [crc_pkg::VAL_W-1:0]  b,
	input  logic [crc_pkg::T_W-1:0]           ta,
	input  logic [crc_pkg::T_W-1:0]           tb,
	input  logic [crc_pkg::T_W-1:0]           t,
	output logic signed [crc_pkg::VAL_W-1:0]  q
);
	import crc_pkg::*;

	localparam int HALF = VAL_W / 2;

	typedef struct packed {
		logic [VAL_W-1:0] w;
		logic [DEN_W:0]   rem;
		logic [DEN_W:0]   d2;
		logic             neg;
	} dv_t;

	logic signed [VAL_W-1:0]        a_s1, b_s1;
	logic signed [T_W:0]            d1_s1, d0_s1;
	logic [DEN_W-1:0]               den_s1, den_s2, den_s3;
	logic signed [HALF+T_W+1:0]     pal_m, pah_m, pbl_m, pbh_m;
	logic signed [HALF+T_W+1:0]     pal_s2, pah_s2, pbl_s2, pbh_s2;
	logic signed [VAL_W-1:0]        pa_s3, pb_s3;
	logic [VAL_W-1:0]               n2_s4;
	logic [DEN_W:0]                 d2_s4, d2_s5;
	logic                           neg_s5;
	logic [VAL_W-1:0]               mag_s5;
	dv_t                            dv_s [VAL_W];
	logic signed [VAL_W-1:0]        q_s6;

	assign pal_m = $signed({1'b0, a_s1[HALF-1:0]}) * d1_s1;
	assign pah_m = $signed(a_s1[VAL_W-1:HALF]) * d1_s1;
	assign pbl_m = $signed({1'b0, b_s1[HALF-1:0]}) * d0_s1;
	assign pbh_m = $signed(b_s1[VAL_W-1:HALF]) * d0_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= a;
			b_s1   <= b;
			d1_s1  <= $signed({1'b0, tb}) - $signed({1'b0, t});
			d0_s1  <= $signed({1'b0, t}) - $signed({1'b0, ta});
			den_s1 <= DEN_W'({1'b0, tb} - {1'b0, ta});
			pal_s2 <= pal_m;
			pah_s2 <= pah_m;
			pbl_s2 <= pbl_m;
			pbh_s2 <= pbh_m;
			den_s2 <= den_s1;
			// products wrap modulo 2^64
			pa_s3  <= VAL_W'(pal_s2) + (VAL_W'(pah_s2) << HALF);
			pb_s3  <= VAL_W'(pbl_s2) + (VAL_W'(pbh_s2) << HALF);
			den_s3 <= den_s2;
			n2_s4  <= VAL_W'((pa_s3 + pb_s3) <<< 1) + VAL_W'(den_s3);
			d2_s4  <= {den_s3, 1'b0};
			neg_s5 <= n2_s4[VAL_W-1];
			mag_s5 <= n2_s4[VAL_W-1] ? -n2_s4 : n2_s4;
			d2_s5  <= d2_s4;
		end
	end

	for (genvar j = 0; j < VAL_W; j++) begin : g_div
		dv_t            din;
		logic [DEN_W+1:0] tr;
		logic             ge;
		if (j == 0) begin : g_first
			assign din = '{w: mag_s5, rem: '0, d2: d2_s5, neg: neg_s5};
		end else begin : g_next
			assign din = dv_s[j-1];
		end
		assign tr = {din.rem, din.w[VAL_W-1]};
		assign ge = tr >= {1'b0, din.d2};
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[j].w   <= {din.w[VAL_W-2:0], ge};
				dv_s[j].rem <= ge ? (DEN_W+1)'(tr - {1'b0, din.d2}) : tr[DEN_W:0];
				dv_s[j].d2  <= din.d2;
				dv_s[j].neg <= din.neg;
			end
		end
	end

	// floor of a negative quotient: -q, minus one more when inexact
	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_s[VAL_W-1].neg) begin
				q_s6 <= (dv_s[VAL_W-1].rem != '0) ? ~dv_s[VAL_W-1].w : -dv_s[VAL_W-1].w;
			end else begin
				q_s6 <= dv_s[VAL_W-1].w;
			end
		end
	end

	assign q = q_s6;

endmodule

// ===== hdl/centripetal_catmull_rom_segment.sv =====
// Top level: knot front end, point issue, t divider and Barry-Goldman pyramid.
// Throughput: n+1 points per item (13 at reset), one point a cycle from the
// point issue counter while the output does not stall; the knot pipeline takes
// a new item every cycle unless the output stalls or the issue is busy.
// Reset: arst_n clears all valid bits and sets segments to 12; no clearing pass.
// A stall on the output freezes the whole pipeline.
module centripetal_catmull_rom_segment (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [crc_pkg::SEG_W-1:0]     wr_data,
	input  logic                          pts_valid,
	output logic                          pts_stall,
	input  crc_pkg::pts_t                 pts,
	output logic                          crv_valid,
	input  logic                          crv_stall,
	output crc_pkg::crv_t                 crv
);
	import crc_pkg::*;

	localparam int SIDE_N = 3 * LERP_LAT;

	typedef struct packed {
		pts_t              p;
		logic [T_W-1:0]    t1;
		logic [T_W-1:0]    t2;
		logic [T_W-1:0]    t3;
		logic              last;
		logic              start;
		logic              degen;
		logic [SEG_W-1:0]  n;
		logic [TDIV_W-1:0] w;
		logic [SEG_W-1:0]  rem;
	} td_t;

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [VAL_W-1:0] v);
		logic signed [VAL_W-1:0] hi;
		logic signed [VAL_W-1:0] lo;
		hi = (VAL_W'(1) <<< (COORD_W - 1)) - 1;
		lo = -(VAL_W'(1) <<< (COORD_W - 1));
		if (v > hi) return hi[COORD_W-1:0];
		if (v < lo) return lo[COORD_W-1:0];
		return v[COORD_W-1:0];
	endfunction

	logic [SEG_W-1:0]  seg_q;
	logic              adv, fadv, load, last_issue;
	logic              fv_s [KNOT_LAT];
	pts_t              fp_s [KNOT_LAT];
	logic [KNOT_W-1:0] k01, k12, k23;
	logic              busy_q;
	logic [SEG_W-1:0]  idx_q, n_q, n_sat;
	pts_t              it_q;
	logic [T_W-1:0]    t1_q, t2_q, t3_q;
	logic [KNOT_W-1:0] k12_q;
	logic              degen_q;
	td_t               td_s [TDIV_W+1];
	logic              tv_s [TDIV_W+1];
	side_t             sd_s [SIDE_N];
	logic              sv_s [SIDE_N];
	side_t             s0, s1, s2, s3;
	td_t               te;
	logic signed [VAL_W-1:0] a1x, a2x, a3x, a1y, a2y, a3y, b1x, b2x, b1y, b2y, cx, cy;
	logic              crv_valid_q;
	crv_t              crv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= SEG_W'(SEG_RESET);
		end else if (wr_en) begin
			seg_q <= wr_data;
		end
	end

	assign n_sat = (seg_q == '0) ? SEG_W'(1) :
		(({1'b0, seg_q}) > (SEG_W+1)'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : seg_q;

	assign adv        = !crv_valid_q || !crv_stall;
	assign last_issue = idx_q == n_q;
	assign fadv       = adv && (!fv_s[KNOT_LAT-1] || !busy_q || last_issue);
	assign load       = fadv && fv_s[KNOT_LAT-1];
	assign pts_stall  = !fadv;

	// front end: knots computed while the points ride alongside
	crc_knot u_k01 (.clk(clk), .en(fadv), .ax(pts.p0_x), .ay(pts.p0_y),
		.bx(pts.p1_x), .by(pts.p1_y), .k(k01));
	crc_knot u_k12 (.clk(clk), .en(fadv), .ax(pts.p1_x), .ay(pts.p1_y),
		.bx(pts.p2_x), .by(pts.p2_y), .k(k12));
	crc_knot u_k23 (.clk(clk), .en(fadv), .ax(pts.p2_x), .ay(pts.p2_y),
		.bx(pts.p3_x), .by(pts.p3_y), .k(k23));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < KNOT_LAT; j++) fv_s[j] <= 1'b0;
		end else if (fadv) begin
			fv_s[0] <= pts_valid;
			for (int j = 1; j < KNOT_LAT; j++) fv_s[j] <= fv_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (fadv) begin
			fp_s[0] <= pts;
			for (int j = 1; j < KNOT_LAT; j++) fp_s[j] <= fp_s[j-1];
		end
	end

	// point issue: one curve point per cycle while the output does not stall, next item loads on the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (adv && busy_q) begin
			if (last_issue) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + SEG_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			it_q    <= fp_s[KNOT_LAT-1];
			n_q     <= n_sat;
			k12_q   <= k12;
			t1_q    <= T_W'(k01);
			t2_q    <= T_W'(k01) + T_W'(k12);
			t3_q    <= T_W'(k01) + T_W'(k12) + T_W'(k23);
			degen_q <= (k01 == '0) || (k12 == '0) || (k23 == '0);
		end
	end

	// t = t1 + floor(k12*i/n), restoring divider one quotient bit per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= TDIV_W; j++) tv_s[j] <= 1'b0;
		end else if (adv) begin
			tv_s[0] <= busy_q;
			for (int j = 1; j <= TDIV_W; j++) tv_s[j] <= tv_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			td_s[0].p     <= it_q;
			td_s[0].t1    <= t1_q;
			td_s[0].t2    <= t2_q;
			td_s[0].t3    <= t3_q;
			td_s[0].last  <= last_issue;
			td_s[0].start <= idx_q == '0;
			td_s[0].degen <= degen_q;
			td_s[0].n     <= n_q;
			td_s[0].w     <= TDIV_W'(k12_q) * TDIV_W'(idx_q);
			td_s[0].rem   <= '0;
		end
	end

	for (genvar j = 1; j <= TDIV_W; j++) begin : g_tdiv
		logic [SEG_W:0] tr;
		logic           ge;
		td_t            nx;
		assign tr = {td_s[j-1].rem, td_s[j-1].w[TDIV_W-1]};
		assign ge = tr >= {1'b0, td_s[j-1].n};
		always_comb begin
			nx     = td_s[j-1];
			nx.w   = {td_s[j-1].w[TDIV_W-2:0], ge};
			nx.rem = ge ? SEG_W'(tr - {1'b0, td_s[j-1].n}) : tr[SEG_W-1:0];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				td_s[j] <= nx;
			end
		end
	end

	assign te = td_s[TDIV_W];
	assign s0 = '{t1: te.t1, t2: te.t2, t3: te.t3, t: te.t1 + T_W'(te.w),
		p1_x: te.p.p1_x, p1_y: te.p.p1_y, last: te.last, degen: te.degen,
		start: te.start};

	// side data delayed to match each pyramid level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < SIDE_N; j++) sv_s[j] <= 1'b0;
		end else if (adv) begin
			sv_s[0] <= tv_s[TDIV_W];
			for (int j = 1; j < SIDE_N; j++) sv_s[j] <= sv_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s[0] <= s0;
			for (int j = 1; j < SIDE_N; j++) sd_s[j] <= sd_s[j-1];
		end
	end

	assign s1 = sd_s[LERP_LAT-1];
	assign s2 = sd_s[2*LERP_LAT-1];
	assign s3 = sd_s[SIDE_N-1];

	crc_lerp u_a1x (.clk(clk), .en(adv), .a(VAL_W'(te.p.p0_x)), .b(VAL_W'(te.p.p1_x)),
		.ta('0), .tb(s0.t1), .t(s0.t), .q(a1x));
	crc_lerp u_a2x (.clk(clk), .en(adv), .a(VAL_W'(te.p.p1_x)), .b(VAL_W'(te.p.p2_x)),
		.ta(s0.t1), .tb(s0.t2), .t(s0.t), .q(a2x));
	crc_lerp u_a3x (.clk(clk), .en(adv), .a(VAL_W'(te.p.p2_x)), .b(VAL_W'(te.p.p3_x)),
		.ta(s0.t2), .tb(s0.t3), .t(s0.t), .q(a3x));
	crc_lerp u_a1y (.clk(clk), .en(adv), .a(VAL_W'(te.p.p0_y)), .b(VAL_W'(te.p.p1_y)),
		.ta('0), .tb(s0.t1), .t(s0.t), .q(a1y));
	crc_lerp u_a2y (.clk(clk), .en(adv), .a(VAL_W'(te.p.p1_y)), .b(VAL_W'(te.p.p2_y)),
		.ta(s0.t1), .tb(s0.t2), .t(s0.t), .q(a2y));
	crc_lerp u_a3y (.clk(clk), .en(adv), .a(VAL_W'(te.p.p2_y)), .b(VAL_W'(te.p.p3_y)),
		.ta(s0.t2), .tb(s0.t3), .t(s0.t), .q(a3y));

	crc_lerp u_b1x (.clk(clk), .en(adv), .a(a1x), .b(a2x),
		.ta('0), .tb(s1.t2), .t(s1.t), .q(b1x));
	crc_lerp u_b2x (.clk(clk), .en(adv), .a(a2x), .b(a3x),
		.ta(s1.t1), .tb(s1.t3), .t(s1.t), .q(b2x));
	crc_lerp u_b1y (.clk(clk), .en(adv), .a(a1y), .b(a2y),
		.ta('0), .tb(s1.t2), .t(s1.t), .q(b1y));
	crc_lerp u_b2y (.clk(clk), .en(adv), .a(a2y), .b(a3y),
		.ta(s1.t1), .tb(s1.t3), .t(s1.t), .q(b2y));

	crc_lerp u_cx (.clk(clk), .en(adv), .a(b1x), .b(b2x),
		.ta(s2.t1), .tb(s2.t2), .t(s2.t), .q(cx));
	crc_lerp u_cy (.clk(clk), .en(adv), .a(b1y), .b(b2y),
		.ta(s2.t1), .tb(s2.t2), .t(s2.t), .q(cy));

	// output register; start point and degenerate runs carry p1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crv_valid_q <= 1'b0;
		end else if (adv) begin
			crv_valid_q <= sv_s[SIDE_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			crv_q.out_x      <= (s3.start || s3.degen) ? s3.p1_x : sat_coord(cx);
			crv_q.out_y      <= (s3.start || s3.degen) ? s3.p1_y : sat_coord(cy);
			crv_q.last       <= s3.last;
			crv_q.degenerate <= s3.degen;
		end
	end

	assign crv_valid = crv_valid_q;
	assign crv       = crv_q;

endmodule

// ===== hdl/crc_chk.sv =====
// Port-level checker for the segment evaluator, bound to the top level.
module crc_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      wr_en,
	input logic [crc_pkg::SEG_W-1:0] wr_data,
	input logic                      pts_valid,
	input logic                      pts_stall,
	input crc_pkg::pts_t             pts,
	input logic                      crv_valid,
	input logic                      crv_stall,
	input crc_pkg::crv_t             crv
);
	import crc_pkg::*;

	logic          in_xfer, out_xfer;
	logic [15:0]   open_q;
	logic [SEG_W:0] run_q;
	logic          mid_q, deg_q;

	assign in_xfer  = pts_valid && !pts_stall;
	assign out_xfer = crv_valid && !crv_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
			run_q  <= '0;
			mid_q  <= 1'b0;
			deg_q  <= 1'b0;
		end else begin
			open_q <= open_q + 16'(in_xfer) - 16'(out_xfer && crv.last);
			if (out_xfer) begin
				mid_q <= !crv.last;
				deg_q <= crv.degenerate;
				run_q <= crv.last ? '0 : run_q + (SEG_W+1)'(1);
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		crv_valid && crv_stall |=> crv_valid && $stable(crv))
		else $error("stalled curve point changed");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> open_q != '0)
		else $error("curve point without an open item");

	a_deg_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && mid_q |-> crv.degenerate == deg_q)
		else $error("degenerate flag changed within a run");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !crv.last |-> run_q < (SEG_W+1)'(MAX_SEGMENTS))
		else $error("run longer than the segment limit");

	// unused by the checks but part of the port set
	logic unused_cfg;
	assign unused_cfg = wr_en ^ (^wr_data) ^ (^pts);

endmodule

bind centripetal_catmull_rom_segment crc_chk u_crc_chk (.*);
